### rtl/crf_pkg.sv
// shared types, constants and color conversion for the clipped rectangle fill core
package crf_pkg;

  localparam int CoordW        = 13;
  localparam int QW            = 16;
  localparam int ChanInW       = 9;
  localparam int ChanW         = 8;
  localparam int ColorW        = 24;
  localparam int AddrW         = 32;
  localparam int PitchW        = 16;
  localparam int BytesPerPixel = 4;
  localparam int PixShift      = $clog2(BytesPerPixel);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_FB_WIDTH     = 2'd0,
    REG_FB_HEIGHT    = 2'd1,
    REG_ROW_PITCH    = 2'd2,
    REG_BASE_ADDRESS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e                mode;
    logic [QW-1:0]        left_q;
    logic [QW-1:0]        top_q;
    logic [QW-1:0]        right_q;
    logic [QW-1:0]        bottom_q;
    logic [ChanInW-1:0]   red;
    logic [ChanInW-1:0]   green;
    logic [ChanInW-1:0]   blue;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ColorW-1:0] color;
    logic [AddrW-1:0]  row_addr;
  } setup_t;

  typedef struct packed {
    logic load;
    logic tick;
  } step_t;

  typedef struct packed {
    logic [AddrW-1:0]  pixel_address;
    logic [ColorW-1:0] pixel_word;
    logic              last_pixel;
  } result_t;

  // round(c*255/256), saturated at 255
  function automatic logic [ChanW-1:0] to_channel(logic [ChanInW-1:0] c);
    logic [16:0] acc;
    acc = {c, 8'b0} - {8'b0, c} + 17'd128;
    if (acc[16:8] > 9'd255) begin
      to_channel = 8'hff;
    end else begin
      to_channel = acc[15:8];
    end
  endfunction

endpackage

### rtl/crf_setup.sv
// rectangle setup: corner rounding, clipping, color packing and first row address
module crf_setup import crf_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int MAX_DIM         = 4096
) (
  input  item_t             item_i,
  input  logic [CoordW-1:0] fb_width_i,
  input  logic [CoordW-1:0] fb_height_i,
  input  logic [PitchW-1:0] row_pitch_i,
  input  logic [AddrW-1:0]  base_address_i,
  output setup_t            setup_o
);

  localparam int RW     = 18 - COORD_FRAC_BITS;
  localparam int CW     = (RW > CoordW + 1) ? RW : CoordW + 1;
  localparam int DimLim = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [16:0] Half = 17'(1 << (COORD_FRAC_BITS - 1));
  localparam logic [16:0] Bias = 17'((1 << COORD_FRAC_BITS) - 1);

  // add one half, then truncate toward zero
  function automatic logic signed [CW-1:0] round_coord(logic [QW-1:0] q);
    logic signed [16:0] s;
    logic signed [16:0] adj;
    s   = signed'({q[QW-1], q} + Half);
    adj = s[16] ? signed'(s + Bias) : s;
    round_coord = CW'(adj >>> COORD_FRAC_BITS);
  endfunction

  logic signed [CW-1:0] rl, rt, rr, rb;
  logic signed [CW-1:0] minx, miny, maxx, maxy;
  logic signed [CW-1:0] wl, hl;
  logic [CoordW-1:0]    wlim, hlim;
  logic [CoordW+PitchW-1:0] row_off;

  always_comb begin
    rl = round_coord(item_i.left_q);
    rt = round_coord(item_i.top_q);
    rr = round_coord(item_i.right_q);
    rb = round_coord(item_i.bottom_q);

    wlim = (32'(fb_width_i) < MAX_DIM) ? fb_width_i : CoordW'(DimLim);
    hlim = (32'(fb_height_i) < MAX_DIM) ? fb_height_i : CoordW'(DimLim);
    wl   = signed'(CW'(wlim));
    hl   = signed'(CW'(hlim));

    minx = (rl < 0) ? '0 : rl;
    miny = (rt < 0) ? '0 : rt;
    maxx = (rr > wl) ? wl : rr;
    maxy = (rb > hl) ? hl : rb;

    setup_o.empty  = (minx >= maxx) || (miny >= maxy);
    setup_o.left   = CoordW'(minx);
    setup_o.top    = CoordW'(miny);
    setup_o.right  = CoordW'(maxx);
    setup_o.bottom = CoordW'(maxy);
    setup_o.color  = {to_channel(item_i.red), to_channel(item_i.green),
                      to_channel(item_i.blue)};

    row_off = {{PitchW{1'b0}}, setup_o.top} * {{CoordW{1'b0}}, row_pitch_i};
    setup_o.row_addr = base_address_i + (AddrW'(setup_o.left) << PixShift)
                     + AddrW'(row_off);
  end

endmodule

### rtl/crf_walker.sv
// fill state and pixel walk, at most one pixel write per tick
module crf_walker import crf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  step_t             step_i,
  input  setup_t            setup_i,
  input  logic [PitchW-1:0] row_pitch_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  logic              busy_q, busy_d;
  logic [CoordW-1:0] rect_left_q, rect_left_d;
  logic [CoordW-1:0] rect_right_q, rect_right_d;
  logic [CoordW-1:0] rect_bottom_q, rect_bottom_d;
  logic [CoordW-1:0] cursor_x_q, cursor_x_d;
  logic [CoordW-1:0] cursor_y_q, cursor_y_d;
  logic [AddrW-1:0]  row_address_q, row_address_d;
  logic [ColorW-1:0] pixel_color_q, pixel_color_d;

  logic [CoordW-1:0] offset;
  logic              row_end;
  logic              last;

  always_comb begin
    offset  = cursor_x_q - rect_left_q;
    row_end = ({1'b0, cursor_x_q} + 1'b1) >= {1'b0, rect_right_q};
    last    = row_end && (({1'b0, cursor_y_q} + 1'b1) >= {1'b0, rect_bottom_q});

    res_valid_o         = step_i.tick && busy_q;
    res_o.pixel_address = row_address_q + (AddrW'(offset) << PixShift);
    res_o.pixel_word    = pixel_color_q;
    res_o.last_pixel    = last;

    busy_d        = busy_q;
    rect_left_d   = rect_left_q;
    rect_right_d  = rect_right_q;
    rect_bottom_d = rect_bottom_q;
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    row_address_d = row_address_q;
    pixel_color_d = pixel_color_q;

    if (step_i.load) begin
      pixel_color_d = setup_i.color;
      busy_d        = !setup_i.empty;
      if (!setup_i.empty) begin
        rect_left_d   = setup_i.left;
        rect_right_d  = setup_i.right;
        rect_bottom_d = setup_i.bottom;
        cursor_x_d    = setup_i.left;
        cursor_y_d    = setup_i.top;
        row_address_d = setup_i.row_addr;
      end
    end else if (res_valid_o) begin
      if (last) begin
        busy_d = 1'b0;
      end else if (row_end) begin
        cursor_x_d    = rect_left_q;
        cursor_y_d    = cursor_y_q + 1'b1;
        row_address_d = row_address_q + AddrW'(row_pitch_i);
      end else begin
        cursor_x_d = cursor_x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      rect_left_q   <= '0;
      rect_right_q  <= '0;
      rect_bottom_q <= '0;
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      row_address_q <= '0;
      pixel_color_q <= '0;
    end else begin
      busy_q        <= busy_d;
      rect_left_q   <= rect_left_d;
      rect_right_q  <= rect_right_d;
      rect_bottom_q <= rect_bottom_d;
      cursor_x_q    <= cursor_x_d;
      cursor_y_q    <= cursor_y_d;
      row_address_q <= row_address_d;
      pixel_color_q <= pixel_color_d;
    end
  end

  a_load_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.load && !setup_i.empty |=> busy_q)
    else $error("non-empty load did not arm the fill");

  a_empty_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.load && setup_i.empty |=> !busy_q)
    else $error("empty load left the fill armed");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_pixel |=> !busy_q)
    else $error("fill still busy after last pixel");

  a_cursor_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cursor_x_q >= rect_left_q) && (cursor_x_q < rect_right_q)
               && (cursor_y_q < rect_bottom_q))
    else $error("cursor outside rectangle while busy");

endmodule

### rtl/clipped_rectangle_fill_core.sv
// top level of the clipped rectangle fill core: stream ports, registers, item pipeline
//
// The core takes one item per clock on the input stream and gives at most one pixel write per
// item on the output stream. A load item (tuser 0) rounds the rectangle corners to whole pixels,
// clips them to the frame, converts the three color components to 8-bit channels and arms the
// fill; it gives no output and aborts any fill still in progress. Each tick item (tuser 1)
// gives the next pixel write of the armed fill, row by row from top-left, with tlast on the
// final pixel; a tick while no fill is armed gives nothing. Throughput is one item per cycle while
// the output does not stall; an item goes from input acceptance to the pixel write on the output
// through one input register, then the setup or walk logic and the result register. The input
// side only stalls when the result register holds a pixel write that the sink has not taken.
// Frame size and base address are sampled at load, the row pitch at load and at each row
// change; write them over the APB port only while the core is idle.
module clipped_rectangle_fill_core import crf_pkg::*; #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int MAX_DIM         = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // left_q[15:0], top_q[31:16], right_q[47:32], bottom_q[63:48],
  // red[72:64], green[81:73], blue[90:82], zero fill above
  input  logic [95:0] s_axis_tdata_i,
  // mode[0]
  input  logic        s_axis_tuser_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_address[31:0], pixel_word[55:32]
  output logic [55:0] m_axis_tdata_o,
  // last_pixel
  output logic        m_axis_tlast_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [CoordW-1:0] fb_width_q, fb_height_q;
  logic [PitchW-1:0] row_pitch_q;
  logic [AddrW-1:0]  base_address_q;
  reg_idx_e          reg_idx;
  logic              reg_write;

  // input register
  logic   in_valid_q, in_valid_d;
  item_t  in_q, in_item;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    out_free;
  logic    fire;
  step_t   step;
  setup_t  setup;
  logic    res_valid;
  result_t res;

  // register port: always ready, write on the access phase
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_FB_WIDTH:     prdata = 32'(fb_width_q);
      REG_FB_HEIGHT:    prdata = 32'(fb_height_q);
      REG_ROW_PITCH:    prdata = 32'(row_pitch_q);
      REG_BASE_ADDRESS: prdata = base_address_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q     <= CoordW'(1280);
      fb_height_q    <= CoordW'(720);
      row_pitch_q    <= PitchW'(5120);
      base_address_q <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        REG_FB_WIDTH:     fb_width_q     <= pwdata[CoordW-1:0];
        REG_FB_HEIGHT:    fb_height_q    <= pwdata[CoordW-1:0];
        REG_ROW_PITCH:    row_pitch_q    <= pwdata[PitchW-1:0];
        REG_BASE_ADDRESS: base_address_q <= pwdata;
        default:          ;
      endcase
    end
  end

  // unpack the input item
  always_comb begin
    in_item.mode     = mode_e'(s_axis_tuser_i);
    in_item.left_q   = s_axis_tdata_i[15:0];
    in_item.top_q    = s_axis_tdata_i[31:16];
    in_item.right_q  = s_axis_tdata_i[47:32];
    in_item.bottom_q = s_axis_tdata_i[63:48];
    in_item.red      = s_axis_tdata_i[72:64];
    in_item.green    = s_axis_tdata_i[81:73];
    in_item.blue     = s_axis_tdata_i[90:82];
  end

  // pipeline flow: the held item moves on whenever the result register can take its result
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  assign step.load = fire && (in_q.mode == MODE_LOAD);
  assign step.tick = fire && (in_q.mode == MODE_TICK);

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= in_item;
    end
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  crf_setup #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .MAX_DIM         (MAX_DIM)
  ) u_setup (
    .item_i         (in_q),
    .fb_width_i     (fb_width_q),
    .fb_height_i    (fb_height_q),
    .row_pitch_i    (row_pitch_q),
    .base_address_i (base_address_q),
    .setup_o        (setup)
  );

  crf_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .setup_i     (setup),
    .row_pitch_i (row_pitch_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.pixel_word, out_q.pixel_address};
  assign m_axis_tlast_o  = out_q.last_pixel;

endmodule

### test/crf_fill_checker.sv
`timescale 1ns / 100ps
// pixel write predictor and checker for the clipped rectangle fill core
module crf_fill_checker import crf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [95:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [55:0] out_data_i,
  input  logic        out_last_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int FracBits = 4;
  localparam int MaxDim   = 4096;
  localparam int Half     = 1 << (FracBits - 1);
  localparam int ChanMax  = 255;

  // register copy
  logic [CoordW-1:0] frame_w;
  logic [CoordW-1:0] frame_h;
  logic [PitchW-1:0] pitch;
  logic [AddrW-1:0]  frame_base;

  // fill walk
  logic [CoordW-1:0] rect_l;
  logic [CoordW-1:0] rect_r;
  logic [CoordW-1:0] rect_b;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  logic [AddrW-1:0]  row_base;
  logic [ColorW-1:0] fill_color;
  logic              filling;

  result_t           pixel_writes_q[$];

  // add one half, truncate toward zero
  function automatic int to_pixel(logic [QW-1:0] q);
    int s;
    s = int'($signed(q)) + Half;
    if (s >= 0) return s >>> FracBits;
    return -((-s) >>> FracBits);
  endfunction

  function automatic logic [ChanW-1:0] to_chan(logic [ChanInW-1:0] c);
    int v;
    v = (int'(c) * 255 + 128) >> 8;
    return (v > ChanMax) ? ChanW'(ChanMax) : ChanW'(v);
  endfunction

  task automatic apply_reg_write(logic [3:0] addr, logic [31:0] data);
    case (reg_idx_e'(addr[3:2]))
      REG_FB_WIDTH:     frame_w = data[CoordW-1:0];
      REG_FB_HEIGHT:    frame_h = data[CoordW-1:0];
      REG_ROW_PITCH:    pitch = data[PitchW-1:0];
      REG_BASE_ADDRESS: frame_base = data;
      default: ;
    endcase
  endtask

  task automatic load_rect(logic [95:0] d);
    int x0, y0, x1, y1, xlim, ylim;
    x0 = to_pixel(d[15:0]);
    y0 = to_pixel(d[31:16]);
    x1 = to_pixel(d[47:32]);
    y1 = to_pixel(d[63:48]);
    xlim = (int'(frame_w) < MaxDim) ? int'(frame_w) : MaxDim;
    ylim = (int'(frame_h) < MaxDim) ? int'(frame_h) : MaxDim;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > xlim) x1 = xlim;
    if (y1 > ylim) y1 = ylim;
    fill_color = {to_chan(d[72:64]), to_chan(d[81:73]), to_chan(d[90:82])};
    if (x0 >= x1 || y0 >= y1) begin
      filling = 1'b0;
    end else begin
      rect_l   = CoordW'(x0);
      rect_r   = CoordW'(x1);
      rect_b   = CoordW'(y1);
      col      = CoordW'(x0);
      row      = CoordW'(y0);
      row_base = frame_base + AddrW'(x0 * BytesPerPixel) + AddrW'(y0) * AddrW'(pitch);
      filling  = 1'b1;
    end
  endtask

  task automatic tick_fill();
    result_t px;
    logic    row_end;
    if (!filling) return;
    row_end          = (int'(col) + 1) >= int'(rect_r);
    px.pixel_address = row_base + AddrW'(col - rect_l) * AddrW'(BytesPerPixel);
    px.pixel_word    = fill_color;
    px.last_pixel    = row_end && ((int'(row) + 1) >= int'(rect_b));
    pixel_writes_q.push_back(px);
    if (px.last_pixel) begin
      filling = 1'b0;
    end else if (row_end) begin
      col      = rect_l;
      row      = row + 1'b1;
      row_base = row_base + AddrW'(pitch);
    end else begin
      col = col + 1'b1;
    end
  endtask

  task automatic check_pixel(logic [55:0] d, logic last);
    result_t want;
    if (pixel_writes_q.size() == 0) begin
      $error("unexpected pixel write: address %h word %h last %b", d[31:0], d[55:32], last);
      fail_count_o++;
      return;
    end
    want = pixel_writes_q.pop_front();
    if (d[31:0] !== want.pixel_address) begin
      $error("pixel_address mismatch: expected %h, actual %h", want.pixel_address, d[31:0]);
      fail_count_o++;
    end
    if (d[55:32] !== want.pixel_word) begin
      $error("pixel_word mismatch: expected %h, actual %h", want.pixel_word, d[55:32]);
      fail_count_o++;
    end
    if (last !== want.last_pixel) begin
      $error("last_pixel mismatch: expected %b, actual %b", want.last_pixel, last);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w    = 13'd1280;
      frame_h    = 13'd720;
      pitch      = 16'd5120;
      frame_base = '0;
      rect_l     = '0;
      rect_r     = '0;
      rect_b     = '0;
      col        = '0;
      row        = '0;
      row_base   = '0;
      fill_color = '0;
      filling    = 1'b0;
      pixel_writes_q.delete();
      pending_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) apply_reg_write(paddr_i, pwdata_i);
      if (out_valid_i && out_ready_i) check_pixel(out_data_i, out_last_i);
      if (in_valid_i && in_ready_i) begin
        if (mode_e'(in_user_i) == MODE_LOAD) begin
          load_rect(in_data_i);
        end else begin
          tick_fill();
        end
      end
      pending_o = pixel_writes_q.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// testbench top for the clipped rectangle fill core: clock, reset, stimulus and verdict
module tb;
  import crf_pkg::*;

  localparam int SinkHoldCycles = 300;  // long receiver hold-off
  localparam int DrainCycles    = 8;    // margin for the pipeline to settle after the last pixel write
  localparam int GapPct         = 34;
  localparam int CoordScale     = 16;   // 4 fraction bits
  localparam int CoordReach     = 2030; // keeps corners inside the 16-bit fixed point range

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [95:0] s_data;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [55:0] m_data;
  logic        m_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  bit src_gaps;
  bit sink_gaps;
  bit sink_hold_req;
  int sink_hold_left;
  int items_sent;
  // pixel extent used to place random rectangles near the clip edges
  int frame_xlim;
  int frame_ylim;

  clipped_rectangle_fill_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  crf_fill_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_last_i   (m_last),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // pixel write sink: random stalls, or a long hold-off when asked for one
  initial begin
    m_ready        = 1'b0;
    sink_hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_ready <= 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req  = 1'b0;
        sink_hold_left = SinkHoldCycles;
        m_ready <= 1'b0;
      end else begin
        m_ready <= !(sink_gaps && $urandom_range(0, 99) < GapPct);
      end
    end
  end

  // pixel corner in fixed point, with a random fraction that still rounds to px when px is not negative
  function automatic logic [QW-1:0] to_q(int px);
    return QW'(px * CoordScale + int'($urandom_range(0, CoordScale - 1)) - CoordScale / 2);
  endfunction

  // color component biased toward zero, full scale and saturation
  function automatic logic [ChanInW-1:0] pick_comp();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return 9'd255;
      2:       return 9'd256;
      3:       return 9'd511;
      default: return ChanInW'($urandom_range(0, 511));
    endcase
  endfunction

  // one item on the input stream; valid stays up when the next item follows directly
  task automatic send_item(mode_e mode, logic [QW-1:0] l, logic [QW-1:0] t,
                           logic [QW-1:0] r, logic [QW-1:0] b,
                           logic [ChanInW-1:0] cr, logic [ChanInW-1:0] cg,
                           logic [ChanInW-1:0] cb);
    @(negedge clk_i);
    while (src_gaps && $urandom_range(0, 99) < GapPct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= {5'b0, cb, cg, cr, b, r, t, l};
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
  endtask

  // tick items carry random bits in the unused load fields
  task automatic send_tick();
    send_item(MODE_TICK, QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom),
              ChanInW'($urandom), ChanInW'($urandom), ChanInW'($urandom));
  endtask

  task automatic fill_rect(int x, int y, int w, int h, int ticks);
    send_item(MODE_LOAD, to_q(x), to_q(y), to_q(x + w), to_q(y + h),
              pick_comp(), pick_comp(), pick_comp());
    repeat (ticks) send_tick();
  endtask

  // small rectangle near the frame, mostly walked to its end, sometimes cut short
  task automatic random_rect();
    int x, y, w, h, ticks;
    x = int'($urandom_range(0, frame_xlim + 10)) - 8;
    y = int'($urandom_range(0, frame_ylim + 10)) - 8;
    w = $urandom_range(1, 9);
    h = $urandom_range(1, 5);
    if ($urandom_range(0, 11) == 0) w = -int'($urandom_range(0, 1));
    ticks = (w > 0) ? w * h + int'($urandom_range(0, 2)) : int'($urandom_range(0, 2));
    if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
    fill_rect(x, y, w, h, ticks);
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          // load with fully random corners and colors
          send_item(MODE_LOAD, QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom),
                    ChanInW'($urandom), ChanInW'($urandom), ChanInW'($urandom));
        end
        1: begin
          repeat ($urandom_range(1, 4)) send_tick();
        end
        default: random_rect();
      endcase
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drop valid, wait for every pixel write, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_frame(int w, int h, int pitch, logic [31:0] base);
    wait_idle();
    write_reg(REG_FB_WIDTH, 32'(w));
    write_reg(REG_FB_HEIGHT, 32'(h));
    write_reg(REG_ROW_PITCH, 32'(pitch));
    write_reg(REG_BASE_ADDRESS, base);
    frame_xlim = (w < 4096) ? w : 4096;
    frame_xlim = (frame_xlim < CoordReach) ? frame_xlim : CoordReach;
    frame_ylim = (h < 4096) ? h : 4096;
    frame_ylim = (frame_ylim < CoordReach) ? frame_ylim : CoordReach;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_valid       = 1'b0;
    s_data        = '0;
    s_user        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_gaps      = 1'b0;
    sink_gaps     = 1'b0;
    sink_hold_req = 1'b0;
    items_sent    = 0;
    frame_xlim    = 1280;
    frame_ylim    = 720;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items on the reset frame (1280 x 720, pitch 5120, base 0)
    send_tick();  // idle tick right after reset
    // most negative corners: empty after clipping, black
    send_item(MODE_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 9'd0, 9'd0, 9'd0);
    send_tick();
    // most positive far corners clip to the frame, full intensity
    send_item(MODE_LOAD, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 9'd256, 9'd256, 9'd256);
    repeat (3) send_tick();
    // single pixel in the bottom-right corner, saturating red
    send_item(MODE_LOAD, to_q(1279), to_q(719), to_q(1280), to_q(720), 9'd511, 9'd0, 9'd128);
    repeat (2) send_tick();
    // corners just below and at the half-pixel step, negative top rounding to zero
    send_item(MODE_LOAD, 16'h0007, 16'hfff7, 16'h0018, 16'h0017, 9'd1, 9'd127, 9'd255);
    repeat (3) send_tick();
    // fill aborted by a new load
    fill_rect(10, 10, 4, 3, 5);
    fill_rect(0, 0, 2, 2, 5);
    // left edge past the right clip limit gives an empty fill
    send_item(MODE_LOAD, to_q(1300), to_q(5), to_q(1400), to_q(9),
              pick_comp(), pick_comp(), pick_comp());
    send_tick();

    // back-to-back stretch, then random stalls on both sides
    run_random(100);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    run_random(100);

    // widest registers, addresses wrap from the very top
    set_frame(8191, 8191, 16'hffff, 32'hffff_ffff);
    // sink stalls for a long time while ticks keep coming
    send_item(MODE_LOAD, to_q(100), to_q(100), to_q(140), to_q(112),
              pick_comp(), pick_comp(), pick_comp());
    sink_hold_req = 1'b1;
    repeat (480) send_tick();
    run_random(150);
    wait_idle();  // sender pauses until every pixel write is out
    run_random(80);

    // zero width, then zero height: every load is empty
    set_frame(0, 720, 5120, 32'h0000_1000);
    run_random(30);
    set_frame(4096, 0, 0, 32'h0);
    run_random(30);

    // tiny frame, clipping on most rectangles, wrap near the top of the address space
    set_frame(16, 12, 64, 32'hffff_ff00);
    run_random(200);

    set_frame(4096, 4096, 16384, $urandom);
    run_random(150);

    set_frame($urandom_range(1, 2047), $urandom_range(1, 2047), $urandom_range(0, 65535),
              $urandom);
    run_random(150);

    set_frame(1280, 720, 5120, 32'h0);
    run_random(150);

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
